// File: hw/rtl/bol_pkg.sv
// bol_pkg: shared constants, operation codes and cell control type
// for the bounded ordered list; no dependencies
package bol_pkg;

  localparam int CAPACITY  = 16;
  localparam int ELEM_BITS = 32;
  localparam int POS_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  localparam logic [CNT_BITS-1:0] CNT_CAPACITY = CNT_BITS'(CAPACITY);

  typedef logic [ELEM_BITS-1:0] elem_t;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic {
    ST_OK    = 1'b0,
    ST_ERROR = 1'b1
  } status_t;

  typedef struct packed {
    logic load;   // take the appended element
    logic shift;  // take the element of the next cell toward the tail
  } cell_ctrl_t;

endpackage

// File: hw/rtl/bol_cell.sv
// bol_cell: one storage cell of the list chain
// depends on bol_pkg
module bol_cell
  import bol_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  elem_t      load_data,
  input  elem_t      neighbor_data,
  output elem_t      data
);

  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= neighbor_data;
    end else begin
      data <= data;
    end
  end

endmodule

// File: hw/rtl/bounded_ordered_list.sv
// bounded_ordered_list: compacting list held in a chain of cells
// a result is registered in the cycle after its input transfer
// throughput: one item per cycle while the output is not stalled; every
// operation, including the cell shift on pop or delete, completes on acceptance
// reset (rst, synchronous): count, length limit and result valid cleared;
// element storage is not cleared
module bounded_ordered_list
  import bol_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CNT_BITS-1:0]  cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           operation,
  input  logic [31:0]          element_value,
  input  logic [POS_BITS-1:0]  position,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic [31:0]          data_out,
  output logic [CNT_BITS-1:0]  count
);

  logic [CNT_BITS-1:0] length_limit;
  logic [CNT_BITS-1:0] count_q;
  logic [CNT_BITS-1:0] count_next;
  logic                status_next;
  logic [31:0]         data_next;
  logic                accept;
  logic                append_go;
  logic                pop_go;
  logic                delete_go;
  logic                room;
  logic                pos_ok;
  elem_t               load_data;
  elem_t               cell_data [CAPACITY];
  cell_ctrl_t          cell_ctrl [CAPACITY];

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign load_data = element_value[ELEM_BITS-1:0];

  assign room   = (count_q < CNT_CAPACITY) &&
                  ((length_limit == '0) || (count_q < length_limit));
  assign pos_ok = {1'b0, position} < count_q;

  always_comb begin
    append_go   = 1'b0;
    pop_go      = 1'b0;
    delete_go   = 1'b0;
    status_next = ST_ERROR;
    data_next   = '0;
    count_next  = count_q;
    unique case (operation)
      OP_APPEND: begin
        if (room) begin
          append_go   = accept;
          status_next = ST_OK;
          count_next  = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (count_q != '0) begin
          pop_go      = accept;
          status_next = ST_OK;
          data_next   = 32'(cell_data[0]);
          count_next  = count_q - 1'b1;
        end
      end
      OP_GET: begin
        if (pos_ok) begin
          status_next = ST_OK;
          data_next   = 32'(cell_data[position]);
        end
      end
      OP_DELETE: begin
        if (pos_ok) begin
          delete_go   = accept;
          status_next = ST_OK;
          count_next  = count_q - 1'b1;
        end
      end
      OP_CLEAR: begin
        status_next = ST_OK;
        count_next  = '0;
      end
      default: begin
      end
    endcase
  end

  // every cell at or behind the removed place pulls from its tail-side neighbor
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].load  = append_go && (count_q == CNT_BITS'(i));
      cell_ctrl[i].shift = pop_go ||
                           (delete_go && (POS_BITS'(i) >= position));
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == CAPACITY - 1) begin : g_last
        bol_cell u_cell (
          .clk           (clk),
          .ctrl          (cell_ctrl[g]),
          .load_data     (load_data),
          .neighbor_data ('0),
          .data          (cell_data[g])
        );
      end else begin : g_mid
        bol_cell u_cell (
          .clk           (clk),
          .ctrl          (cell_ctrl[g]),
          .load_data     (load_data),
          .neighbor_data (cell_data[g+1]),
          .data          (cell_data[g])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= '0;
      count_q      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        length_limit <= cfg_wdata;
      end
      if (accept) begin
        count_q   <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, held while the output transfer stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      data_out <= data_next;
    end
  end

  assign count = count_q;

endmodule

// File: hw/rtl/bol_checker.sv
// bol_checker: port-level assertions for bounded_ordered_list, bound to the top
// depends on bol_pkg
module bol_checker
  import bol_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [2:0]          operation,
  input logic                out_valid,
  input logic                out_ready,
  input logic                status,
  input logic [31:0]         data_out,
  input logic [CNT_BITS-1:0] count
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(data_out) && $stable(count))
    else $error("result changed while stalled");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (operation == OP_CLEAR) |=>
      out_valid && (status == ST_OK) && (count == '0))
    else $error("clear did not empty the list");

  a_full: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (operation == OP_APPEND) && (count == CNT_CAPACITY) |=>
      (status == ST_ERROR) && (count == CNT_CAPACITY))
    else $error("append accepted on a full list");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ERROR) |-> data_out == '0)
    else $error("error result carries data");

  a_get_count: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (operation == OP_GET) |=> count == $past(count))
    else $error("get changed the count");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .operation (operation),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .data_out  (data_out),
  .count     (count)
);

// File: tb/bounded_ordered_list_test.sv
// bounded_ordered_list_test: self-checking testbench for the bounded ordered list
// depends on bol_pkg and bounded_ordered_list; a local list model predicts each result
`timescale 1ns / 1ps

module bounded_ordered_list_test
  import bol_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int IDLE_PERCENT   = 27;

  // operation codes the block does not define
  localparam logic [2:0] OP_UNKNOWN_A = 3'd5;
  localparam logic [2:0] OP_UNKNOWN_B = 3'd6;
  localparam logic [2:0] OP_UNKNOWN_C = 3'd7;

  typedef struct {
    logic [2:0]          op;
    logic [31:0]         value;
    logic [POS_BITS-1:0] pos;
    bit                  hold;   // wait until the list has answered everything
  } list_item_t;

  typedef struct {
    logic                status;
    logic [31:0]         data;
    logic [CNT_BITS-1:0] count;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [CNT_BITS-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          operation = '0;
  logic [31:0]         element_value = '0;
  logic [POS_BITS-1:0] position = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                status;
  logic [31:0]         data_out;
  logic [CNT_BITS-1:0] count;

  list_item_t   pending_items[$];
  list_result_t pending_results[$];
  list_item_t   next_item;
  list_result_t want;

  // list model
  elem_t model_entries [CAPACITY];
  int    model_count;
  int    model_limit;

  // occupancy seen by the stimulus generator, used only to aim positions
  int gen_count;
  int gen_limit;

  int  items_queued;
  int  results_seen;
  int  mismatches;
  int  quiet_cycles;
  bit  calm;

  bounded_ordered_list uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .element_value (element_value),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .data_out      (data_out),
    .count         (count)
  );

  always #4 clk = ~clk;

  function automatic list_result_t list_apply(logic [2:0] op, logic [31:0] value,
                                              logic [POS_BITS-1:0] pos);
    list_result_t r;
    int p;
    r.status = ST_ERROR;
    r.data   = '0;
    p = int'(pos);
    case (op)
      OP_APPEND: begin
        if (model_count < CAPACITY && (model_limit == 0 || model_count < model_limit)) begin
          model_entries[model_count] = elem_t'(value);
          model_count++;
          r.status = ST_OK;
        end
      end
      OP_POP: begin
        if (model_count > 0) begin
          r.data = model_entries[0];
          for (int i = 0; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
          model_count--;
          r.status = ST_OK;
        end
      end
      OP_GET: begin
        if (p < model_count) begin
          r.data   = model_entries[p];
          r.status = ST_OK;
        end
      end
      OP_DELETE: begin
        if (p < model_count) begin
          for (int i = p; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
          model_count--;
          r.status = ST_OK;
        end
      end
      OP_CLEAR: begin
        model_count = 0;
        r.status    = ST_OK;
      end
      default: ;
    endcase
    r.count = CNT_BITS'(model_count);
    return r;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  // nothing in flight and nothing owed: safe to read at the edge without a race
  function automatic bit list_drained();
    return !in_valid && !out_valid && pending_results.size() == 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && !(pending_items[0].hold && !list_drained()) &&
          (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        next_item     = pending_items.pop_front();
        in_valid      <= 1'b1;
        operation     <= next_item.op;
        element_value <= next_item.value;
        position      <= next_item.pos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // monitor: check the oldest expectation first, then predict the new transfer
  always @(posedge clk) begin
    if (rst) begin
      model_count = 0;
      model_limit = 0;
      foreach (model_entries[i]) model_entries[i] = '0;
    end else begin
      if (cfg_wen) model_limit = int'(cfg_wdata);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result status=%0d data=%h count=%0d",
                                  status, data_out, count));
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status || data_out !== want.data || count !== want.count)
            note_mismatch($sformatf(
              "expected status=%0d data=%h count=%0d, got status=%0d data=%h count=%0d",
              want.status, want.data, want.count, status, data_out, count));
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(list_apply(operation, element_value, position));
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_item(logic [2:0] op, logic [31:0] value, logic [POS_BITS-1:0] pos,
                            bit hold = 1'b0);
    list_item_t it;
    it.op    = op;
    it.value = value;
    it.pos   = pos;
    it.hold  = hold;
    pending_items.push_back(it);
    items_queued++;
    case (op)
      OP_APPEND:
        if (gen_count < CAPACITY && (gen_limit == 0 || gen_count < gen_limit)) gen_count++;
      OP_POP:    if (gen_count > 0) gen_count--;
      OP_DELETE: if (int'(pos) < gen_count) gen_count--;
      OP_CLEAR:  gen_count = 0;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 32'h0000_0000;
    if (roll < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [POS_BITS-1:0] pick_pos();
    if (gen_count > 0 && $urandom_range(99) < 80)
      return POS_BITS'($urandom_range(gen_count - 1));
    return POS_BITS'($urandom_range(CAPACITY - 1));
  endfunction

  task automatic queue_random(int n);
    int done;
    int roll;
    int burst;
    done = 0;
    while (done < n) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        // fill run that drives the list toward its limit
        burst = $urandom_range(10, 20);
        for (int i = 0; i < burst; i++) queue_item(OP_APPEND, pick_value(), pick_pos());
        done += burst;
      end else begin
        roll = $urandom_range(99);
        if (roll < 34)      queue_item(OP_APPEND, pick_value(), pick_pos());
        else if (roll < 47) queue_item(OP_POP, pick_value(), pick_pos());
        else if (roll < 72) queue_item(OP_GET, pick_value(), pick_pos());
        else if (roll < 88) queue_item(OP_DELETE, pick_value(), pick_pos());
        else if (roll < 92) queue_item(OP_CLEAR, pick_value(), pick_pos());
        else if (roll < 93) queue_item(OP_UNKNOWN_A, pick_value(), pick_pos());
        else if (roll < 94) queue_item(OP_UNKNOWN_B, pick_value(), pick_pos());
        else if (roll < 95) queue_item(OP_UNKNOWN_C, pick_value(), pick_pos());
        else queue_item(OP_GET, pick_value(), pick_pos(), $urandom_range(99) < 40);
        done++;
      end
    end
    // leave the list well filled so the next limit may land below the count
    burst = $urandom_range(4, 12);
    for (int i = 0; i < burst; i++) queue_item(OP_APPEND, pick_value(), pick_pos());
  endtask

  task automatic wait_idle();
    while (results_seen != items_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= CNT_BITS'(value);
    @(posedge clk);
    cfg_wen   <= 1'b0;
    gen_limit = value;
  endtask

  initial begin
    int limits[8];
    limits = '{16, 1, 5, 0, 15, 3, 10, 7};
    gen_count = 0;
    gen_limit = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, unknown codes, boundaries of position, head and tail
    queue_item(OP_POP, 32'h0, 4'd0);
    queue_item(OP_GET, 32'h0, 4'd0);
    queue_item(OP_DELETE, 32'h0, 4'd15);
    queue_item(OP_UNKNOWN_A, 32'hFFFF_FFFF, 4'd0);
    queue_item(OP_UNKNOWN_B, 32'h0, 4'd15);
    queue_item(OP_UNKNOWN_C, 32'h1234_5678, 4'd3);
    queue_item(OP_CLEAR, 32'h0, 4'd0);
    queue_item(OP_APPEND, 32'h0000_0000, 4'd15);
    queue_item(OP_APPEND, 32'hFFFF_FFFF, 4'd0);
    queue_item(OP_APPEND, 32'h5A5A_A5A5, 4'd7);
    queue_item(OP_GET, 32'hFFFF_FFFF, 4'd0);
    queue_item(OP_GET, 32'h0, 4'd2, 1'b1);
    queue_item(OP_GET, 32'h0, 4'd3);
    queue_item(OP_GET, 32'h0, 4'd15);
    queue_item(OP_DELETE, 32'h0, 4'd1);
    queue_item(OP_GET, 32'h0, 4'd1);
    queue_item(OP_POP, 32'h0, 4'd0);
    queue_item(OP_DELETE, 32'h0, 4'd1);
    queue_item(OP_DELETE, 32'h0, 4'd0);
    queue_item(OP_POP, 32'h0, 4'd0);
    queue_item(OP_APPEND, 32'h8000_0001, 4'd0);
    queue_item(OP_CLEAR, 32'h0, 4'd0);
    queue_item(OP_GET, 32'h0, 4'd0);
    queue_item(OP_APPEND, 32'h7FFF_FFFE, 4'd0);
    queue_item(OP_POP, 32'h0, 4'd0);

    foreach (limits[i]) begin
      write_limit(limits[i]);
      calm = (i == 2);
      queue_random(120);
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bol_pkg.sv
hw/rtl/bol_cell.sv
hw/rtl/bounded_ordered_list.sv
hw/rtl/bol_checker.sv
tb/bounded_ordered_list_test.sv
